// File: rtl/core/ntla_pkg.sv
// Package: shared types, codes and constants for the node table.
`timescale 1ns / 1ps
package ntla_pkg;
    localparam int NODES_DEFAULT = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    localparam logic [1:0] OP_SEEN  = 2'd0;
    localparam logic [1:0] OP_RELAY = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [7:0] CH_ONE = 8'd1;
    localparam logic [7:0] CH_TWO = 8'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] node_mac;
        logic [7:0]  signal_strength;
        logic [31:0] now_ms;
        logic [7:0]  entry_index;
        logic [7:0]  relay_channel;
        logic [7:0]  relay_value;
        logic        chan_ok;
    } cmd_t;
endpackage

// File: rtl/core/ntla_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module ntla_front
    import ntla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [47:0] node_mac,
    input  logic [7:0]  signal_strength,
    input  logic [31:0] now_ms,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  relay_channel,
    input  logic [7:0]  relay_value,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);
    // two-entry queue
    cmd_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       incoming;

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_take && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.operation       = operation;
        incoming.node_mac        = node_mac;
        incoming.signal_strength = signal_strength;
        incoming.now_ms          = now_ms;
        incoming.entry_index     = entry_index;
        incoming.relay_channel   = relay_channel;
        incoming.relay_value     = relay_value;
        incoming.chan_ok         = (relay_channel == CH_ONE) || (relay_channel == CH_TWO);
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// File: rtl/core/ntla_back.sv
// Back end: walks the table for lookups and sweeps and produces the result.
`timescale 1ns / 1ps
module ntla_back
    import ntla_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] timeout,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  result_index,
    output logic [47:0] entry_mac,
    output logic [7:0]  entry_strength,
    output logic [31:0] entry_messages,
    output logic        entry_online,
    output logic [7:0]  entry_relay_one,
    output logic [7:0]  entry_relay_two,
    output logic [8:0]  used_entries,
    output logic [8:0]  went_offline
);
    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [47:0] addr_mem  [NODES];
    logic [7:0]  str_mem   [NODES];
    logic [31:0] seen_mem  [NODES];
    logic [31:0] msg_mem   [NODES];
    logic [15:0] relay_mem [NODES];
    logic [NODES-1:0] online_reg;

    logic [2:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [8:0]    gone_reg;
    cmd_t          cur_reg;

    // registered read port shared by scan, sweep and read
    logic [47:0] rd_addr_reg;
    logic [31:0] rd_seen_reg;
    logic [7:0]  rd_str_reg;
    logic [31:0] rd_msg_reg;
    logic [15:0] rd_relay_reg;
    logic        rd_vld_reg;
    logic [CW-1:0] rd_ptr_reg;

    logic          out_busy;
    logic          issue;
    logic [IW-1:0] issue_idx;
    logic [IW-1:0] rd_idx;
    logic          idx_ok;
    logic [31:0]   age;

    assign out_busy  = out_valid && out_stall;
    assign cmd_take  = (state_reg == S_IDLE) && !out_busy;
    assign issue     = (ptr_reg < count_reg);
    assign issue_idx = ptr_reg[IW-1:0];
    assign rd_idx    = rd_ptr_reg[IW-1:0];
    assign idx_ok    = ({1'b0, cur_reg.entry_index} < 9'(count_reg));
    assign age       = cur_reg.now_ms - rd_seen_reg;
    assign used_entries = 9'(count_reg);

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= addr_mem[issue_idx];
        rd_seen_reg  <= seen_mem[issue_idx];
        rd_str_reg   <= str_mem[issue_idx];
        rd_msg_reg   <= msg_mem[issue_idx];
        rd_relay_reg <= relay_mem[issue_idx];
        rd_ptr_reg   <= ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && rd_vld_reg && rd_addr_reg == cur_reg.node_mac)
        begin
            str_mem[rd_idx]  <= cur_reg.signal_strength;
            seen_mem[rd_idx] <= cur_reg.now_ms;
            msg_mem[rd_idx]  <= rd_msg_reg + 32'd1;
        end
        else if (state_reg == S_SCAN && !rd_vld_reg && !issue && 9'(count_reg) < 9'(NODES))
        begin
            addr_mem[count_reg[IW-1:0]]  <= cur_reg.node_mac;
            str_mem[count_reg[IW-1:0]]   <= cur_reg.signal_strength;
            seen_mem[count_reg[IW-1:0]]  <= cur_reg.now_ms;
            msg_mem[count_reg[IW-1:0]]   <= 32'd1;
            relay_mem[count_reg[IW-1:0]] <= 16'd0;
        end
        else if (state_reg == S_READ && rd_vld_reg && cur_reg.operation == OP_RELAY
                 && idx_ok && cur_reg.chan_ok)
        begin
            if (cur_reg.relay_channel == CH_ONE)
            begin
                relay_mem[rd_idx] <= {rd_relay_reg[15:8], cur_reg.relay_value};
            end
            else
            begin
                relay_mem[rd_idx] <= {cur_reg.relay_value, rd_relay_reg[7:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            online_reg <= '0;
            gone_reg   <= '0;
            rd_vld_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (cmd_valid && !out_busy)
                    begin
                        cur_reg  <= cmd;
                        gone_reg <= '0;
                        ptr_reg  <= '0;
                        unique case (cmd.operation)
                            OP_SEEN:  state_reg <= S_SCAN;
                            OP_SWEEP: state_reg <= S_SWEEP;
                            default:
                            begin
                                ptr_reg   <= CW'(cmd.entry_index);
                                state_reg <= S_READ;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (rd_vld_reg && rd_addr_reg == cur_reg.node_mac)
                    begin
                        online_reg[rd_idx] <= 1'b1;
                        status         <= ST_OK;
                        result_index   <= 8'(rd_ptr_reg);
                        rd_vld_reg     <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                    else if (!rd_vld_reg && !issue && rd_ptr_reg == ptr_reg)
                    begin
                        if (9'(count_reg) < 9'(NODES))
                        begin
                            online_reg[count_reg[IW-1:0]] <= 1'b1;
                            count_reg    <= count_reg + 1'b1;
                            status       <= ST_NEW;
                            result_index <= 8'(count_reg);
                        end
                        else
                        begin
                            status       <= ST_FULL;
                            result_index <= 8'd0;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rd_vld_reg <= issue;
                        if (issue)
                        begin
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                    end
                end
                S_SWEEP:
                begin
                    if (rd_vld_reg && age > timeout && online_reg[rd_idx])
                    begin
                        online_reg[rd_idx] <= 1'b0;
                        gone_reg <= gone_reg + 9'd1;
                    end
                    rd_vld_reg <= issue;
                    if (issue)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else if (!rd_vld_reg)
                    begin
                        status       <= ST_OK;
                        result_index <= 8'd0;
                        state_reg    <= S_DONE;
                    end
                end
                S_READ:
                begin
                    // the read is issued first; its registered data is used once rd_vld_reg is set
                    if (!rd_vld_reg)
                    begin
                        rd_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_vld_reg   <= 1'b0;
                        result_index <= cur_reg.entry_index;
                        status       <= ST_OK;
                        if (!idx_ok || (cur_reg.operation == OP_RELAY && !cur_reg.chan_ok))
                        begin
                            status <= ST_BAD;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // relay writes to a bad channel are blocked by chan_ok in the write path
    logic do_read;
    assign do_read = (cur_reg.operation == OP_READ) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ && rd_vld_reg)
        begin
            entry_mac       <= do_read ? rd_addr_reg : 48'd0;
            entry_strength  <= do_read ? rd_str_reg : 8'd0;
            entry_messages  <= do_read ? rd_msg_reg : 32'd0;
            entry_online    <= do_read ? online_reg[rd_idx] : 1'b0;
            entry_relay_one <= do_read ? rd_relay_reg[7:0] : 8'd0;
            entry_relay_two <= do_read ? rd_relay_reg[15:8] : 8'd0;
            went_offline    <= 9'd0;
        end
        else if (state_reg == S_SCAN || state_reg == S_SWEEP)
        begin
            entry_mac       <= 48'd0;
            entry_strength  <= 8'd0;
            entry_messages  <= 32'd0;
            entry_online    <= 1'b0;
            entry_relay_one <= 8'd0;
            entry_relay_two <= 8'd0;
            went_offline    <= (state_reg == S_SWEEP) ? gone_reg : 9'd0;
        end
    end
endmodule

// File: rtl/core/node_table_learn_and_age_top.sv
// Top level of the node table with address learning and aging.
// A seen item walks the table through its single registered read port until an
// entry matches, or else adds an entry or finds the table full; a sweep walks every
// used entry, and a relay write or read fetches the one entry that it names through
// the same port. A two-deep queue in front of the table engine takes new
// transactions while a result waits. The timeout register may be written only
// while the block is idle.
`timescale 1ns / 1ps
module node_table_learn_and_age_top
    import ntla_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [47:0] node_mac,
    input  logic [7:0]  signal_strength,
    input  logic [31:0] now_ms,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  relay_channel,
    input  logic [7:0]  relay_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  result_index,
    output logic [47:0] entry_mac,
    output logic [7:0]  entry_strength,
    output logic [31:0] entry_messages,
    output logic        entry_online,
    output logic [7:0]  entry_relay_one,
    output logic [7:0]  entry_relay_two,
    output logic [8:0]  used_entries,
    output logic [8:0]  went_offline
);
    logic [31:0] timeout_reg;
    logic        cmd_valid, cmd_take;
    cmd_t        cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    ntla_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .operation, .node_mac, .signal_strength,
        .now_ms, .entry_index, .relay_channel, .relay_value,
        .cmd_valid, .cmd, .cmd_take
    );

    ntla_back #(.NODES(NODES)) u_back (
        .clk, .rst_n, .timeout(timeout_reg), .cmd_valid, .cmd, .cmd_take,
        .out_valid, .out_stall, .status, .result_index, .entry_mac, .entry_strength,
        .entry_messages, .entry_online, .entry_relay_one, .entry_relay_two,
        .used_entries, .went_offline
    );
endmodule

// File: rtl/core/ntla_checker.sv
// Checker: port-level properties of the node table, bound to the top level.
`timescale 1ns / 1ps
module ntla_checker
    import ntla_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] result_index,
    input logic [8:0] used_entries,
    input logic [8:0] went_offline
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result changed while stalled");
    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NEW |-> 9'(result_index) + 9'd1 == used_entries)
        else $error("new entry index does not match count");
    a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> result_index == 8'd0)
        else $error("table full with nonzero index");
    a_gone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> went_offline <= used_entries)
        else $error("more entries aged than exist");
endmodule

bind node_table_learn_and_age_top ntla_checker u_chk (
    .clk, .rst_n, .out_valid, .out_stall, .status, .result_index,
    .used_entries, .went_offline
);

// File: verif/node_table_checker.sv
// Checker: predicts node table results from observed transactions and compares them.
`timescale 1ns / 1ps
module node_table_checker
    import ntla_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [47:0] node_mac,
    input  logic [7:0]  signal_strength,
    input  logic [31:0] now_ms,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  relay_channel,
    input  logic [7:0]  relay_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [7:0]  result_index,
    input  logic [47:0] entry_mac,
    input  logic [7:0]  entry_strength,
    input  logic [31:0] entry_messages,
    input  logic        entry_online,
    input  logic [7:0]  entry_relay_one,
    input  logic [7:0]  entry_relay_two,
    input  logic [8:0]  used_entries,
    input  logic [8:0]  went_offline,
    output int          fail_count,
    output int          pending_results
);
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_index;
        logic [47:0] mac;
        logic [7:0]  strength;
        logic [31:0] messages;
        logic        online;
        logic [7:0]  relay_one;
        logic [7:0]  relay_two;
        logic [8:0]  used;
        logic [8:0]  gone;
    } node_result_t;

    logic [47:0] tbl_mac [NODES];
    logic [7:0]  tbl_strength [NODES];
    logic [31:0] tbl_seen [NODES];
    logic [31:0] tbl_msgs [NODES];
    logic        tbl_online [NODES];
    logic [7:0]  tbl_relay1 [NODES];
    logic [7:0]  tbl_relay2 [NODES];
    int          tbl_used;
    logic [31:0] timeout_ms;
    node_result_t expected_results[$];

    assign pending_results = expected_results.size();

    function automatic node_result_t predict_table_op();
        node_result_t r;
        bit hit;
        r = '0;
        hit = 0;
        case (operation)
            OP_SEEN:
            begin
                for (int i = 0; i < tbl_used; i++)
                    if (!hit && tbl_mac[i] == node_mac)
                    begin
                        hit = 1;
                        tbl_strength[i] = signal_strength;
                        tbl_seen[i] = now_ms;
                        tbl_msgs[i] = tbl_msgs[i] + 32'd1;
                        tbl_online[i] = 1;
                        r.status = ST_OK;
                        r.result_index = 8'(i);
                    end
                if (!hit)
                begin
                    if (tbl_used < NODES)
                    begin
                        tbl_mac[tbl_used] = node_mac;
                        tbl_strength[tbl_used] = signal_strength;
                        tbl_seen[tbl_used] = now_ms;
                        tbl_msgs[tbl_used] = 32'd1;
                        tbl_online[tbl_used] = 1;
                        tbl_relay1[tbl_used] = '0;
                        tbl_relay2[tbl_used] = '0;
                        r.status = ST_NEW;
                        r.result_index = 8'(tbl_used);
                        tbl_used++;
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            OP_RELAY:
            begin
                r.result_index = entry_index;
                if (entry_index >= tbl_used ||
                    (relay_channel != CH_ONE && relay_channel != CH_TWO))
                    r.status = ST_BAD;
                else
                begin
                    r.status = ST_OK;
                    if (relay_channel == CH_ONE)
                        tbl_relay1[entry_index] = relay_value;
                    else
                        tbl_relay2[entry_index] = relay_value;
                end
            end
            OP_SWEEP:
            begin
                r.status = ST_OK;
                for (int i = 0; i < tbl_used; i++)
                    if (now_ms - tbl_seen[i] > timeout_ms && tbl_online[i])
                    begin
                        tbl_online[i] = 0;
                        r.gone++;
                    end
            end
            default:
            begin
                r.result_index = entry_index;
                if (entry_index >= tbl_used)
                    r.status = ST_BAD;
                else
                begin
                    r.status = ST_OK;
                    r.mac = tbl_mac[entry_index];
                    r.strength = tbl_strength[entry_index];
                    r.messages = tbl_msgs[entry_index];
                    r.online = tbl_online[entry_index];
                    r.relay_one = tbl_relay1[entry_index];
                    r.relay_two = tbl_relay2[entry_index];
                end
            end
        endcase
        r.used = 9'(tbl_used);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        node_result_t got;
        node_result_t want;
        if (!rst_n)
        begin
            tbl_used = 0;
            timeout_ms = TIMEOUT_RESET;
            fail_count = 0;
            for (int i = 0; i < NODES; i++)
                tbl_online[i] = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                timeout_ms = cfg_wdata;
            if (in_valid && !in_stall)
                expected_results.push_back(predict_table_op());
            if (out_valid && !out_stall)
            begin
                got = '{status, result_index, entry_mac, entry_strength, entry_messages,
                        entry_online, entry_relay_one, entry_relay_two, used_entries,
                        went_offline};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t: expected %h got %h", $realtime,
                                     want, got);
                    end
                end
            end
        end
    end
endmodule

// File: verif/tb_top.sv
// Testbench top: drives the node table with directed and random transactions.
`timescale 1ns / 1ps
module tb_top;
    import ntla_pkg::*;

    localparam int NODES = NODES_DEFAULT;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [47:0] node_mac;
    logic [7:0]  signal_strength;
    logic [31:0] now_ms;
    logic [7:0]  entry_index;
    logic [7:0]  relay_channel;
    logic [7:0]  relay_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  result_index;
    logic [47:0] entry_mac;
    logic [7:0]  entry_strength;
    logic [31:0] entry_messages;
    logic        entry_online;
    logic [7:0]  entry_relay_one;
    logic [7:0]  entry_relay_two;
    logic [8:0]  used_entries;
    logic [8:0]  went_offline;
    int          fail_count;
    int          pending_results;
    bit          calm;
    logic [47:0] mac_pool [24];
    logic [31:0] clock_ms;

    node_table_learn_and_age_top #(.NODES(NODES)) DUT (.*);

    node_table_checker #(.NODES(NODES)) checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // Receiver stall: random bursts, none in the calm tail.
    initial
    begin
        out_stall = 0;
        forever
        begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    // Valid stays high after acceptance; the next call or the caller drops it.
    task automatic send_op(input logic [1:0] op, input logic [47:0] mac, input logic [7:0] rssi,
                           input logic [31:0] t, input logic [7:0] idx, input logic [7:0] ch,
                           input logic [7:0] val);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1;
        operation <= op;
        node_mac <= mac;
        signal_strength <= rssi;
        now_ms <= t;
        entry_index <= idx;
        relay_channel <= ch;
        relay_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        in_valid <= 0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_op();
        int pick;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 3000);
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NODES));
        if (pick < 40)
            send_op(OP_SEEN, mac_pool[$urandom_range(0, 23)], 8'($urandom), clock_ms,
                    8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 45)
            send_op(OP_SEEN, {$urandom, $urandom}, 8'($urandom), clock_ms, 8'($urandom),
                    8'($urandom), 8'($urandom));
        else if (pick < 65)
            send_op(OP_RELAY, {$urandom, $urandom}, 8'($urandom), clock_ms, idx,
                    ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2)),
                    8'($urandom));
        else if (pick < 75)
            send_op(OP_SWEEP, {$urandom, $urandom}, 8'($urandom),
                    ($urandom_range(0, 9) == 0) ? $urandom : clock_ms, idx,
                    8'($urandom), 8'($urandom));
        else
            send_op(OP_READ, {$urandom, $urandom}, 8'($urandom), clock_ms, idx,
                    8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        in_valid = 0;
        operation = OP_SEEN;
        node_mac = '0;
        signal_strength = '0;
        now_ms = '0;
        entry_index = '0;
        relay_channel = '0;
        relay_value = '0;
        calm = 0;
        clock_ms = 32'hFFFF_0000;
        for (int i = 0; i < 24; i++)
            mac_pool[i] = {$urandom, $urandom};
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: empty table, extremes, updates, wrap of time, sweep, bad accesses.
        send_op(OP_READ, '0, '0, '0, 8'd0, '0, '0);
        send_op(OP_RELAY, '0, '0, '0, 8'd0, CH_ONE, 8'hFF);
        send_op(OP_SWEEP, '0, '0, '1, '0, '0, '0);
        send_op(OP_SEEN, '0, 8'h80, 32'hFFFF_FFF0, '0, '0, '0);
        send_op(OP_SEEN, '1, 8'h7F, '1, '1, '1, '1);
        send_op(OP_SEEN, '0, 8'hFF, 32'd5, '0, '0, '0);
        send_op(OP_RELAY, '0, '0, '0, 8'd1, CH_ONE, 8'hFF);
        send_op(OP_RELAY, '0, '0, '0, 8'd1, CH_TWO, 8'hA5);
        send_op(OP_RELAY, '0, '0, '0, 8'd0, 8'd0, 8'h11);
        send_op(OP_RELAY, '0, '0, '0, 8'd0, 8'd3, 8'h11);
        send_op(OP_RELAY, '0, '0, '0, 8'd255, CH_ONE, 8'h11);
        send_op(OP_READ, '0, '0, '0, 8'd0, '0, '0);
        send_op(OP_READ, '0, '0, '0, 8'd1, '0, '0);
        send_op(OP_READ, '0, '0, '0, 8'd2, '0, '0);
        send_op(OP_READ, '0, '0, '0, 8'd255, '0, '0);
        send_op(OP_SWEEP, '0, '0, 32'd10005, '0, '0, '0);
        send_op(OP_SWEEP, '0, '0, 32'd10006, '0, '0, '0);
        send_op(OP_SWEEP, '0, '0, 32'd20000, '0, '0, '0);
        send_op(OP_READ, '0, '0, '0, 8'd0, '0, '0);
        for (int i = 0; i < NODES; i++)
            send_op(OP_SEEN, 48'h1000 + 48'(i), 8'(i), 32'd3, '0, '0, '0);

        write_timeout(32'd1);
        for (int i = 0; i < 120; i++)
            random_op();
        write_timeout('1);
        for (int i = 0; i < 120; i++)
            random_op();
        write_timeout(32'd4000);

        // Fresh table contents can't be cleared, so later phases reuse the full table.
        for (int i = 0; i < 250; i++)
            random_op();
        write_timeout(32'd0);
        for (int i = 0; i < 40; i++)
            random_op();
        write_timeout(32'd7000);
        calm = 1;
        for (int i = 0; i < 80; i++)
            random_op();
        in_valid <= 0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
